### design/dtb_pkg.sv
// ----------------------------------------------------------------------------
// dtb_pkg
// Shared types, constants and helpers of the decimal to binary64 converter:
// controller commands and status, state encoding, format constants.
// ----------------------------------------------------------------------------
package dtb_pkg;

  // word and field widths
  localparam int WORD_W          = 32;
  localparam int MANT_W          = 64;
  localparam int SCALE_W         = 10;
  localparam int RES_W           = 64;
  localparam int STAT_W          = 2;
  localparam int Q_W             = 64;
  localparam int TOP_W           = 6;
  localparam int EXP_FIELD_W     = 11;

  // defaults for the top level parameters
  localparam int BIG_WORDS_DEF   = 48;
  localparam int SCALE_LIMIT_DEF = 400;

  // binary64 format
  localparam int FRAC_BITS       = 52;
  localparam int PREC_BITS       = 53;
  localparam int SIGN_POS        = 63;
  localparam int EXP_BIAS        = 1023;
  localparam int EXP_MAX         = 1023;
  localparam int EXP_MIN         = -1022;
  localparam int SUB_SCALE       = 1074;
  localparam int TOP_MAX         = 63;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SCALE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVF   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_UNF   = 2'd3;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CHECK,
    OP_MUL5,
    OP_BITS,
    OP_EST,
    OP_WSHIFT,
    OP_BSHIFT,
    OP_CMP,
    OP_EXP,
    OP_TOP,
    OP_QBIT,
    OP_SUBSH,
    OP_ROUND,
    OP_EMIT
  } op_t;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_BITS1,
    ST_EST,
    ST_SHW,
    ST_SHB,
    ST_CMPE,
    ST_EXP,
    ST_OVF,
    ST_BITS2,
    ST_TOP,
    ST_DCMP,
    ST_QBIT,
    ST_DSUB,
    ST_RCMP,
    ST_ROUND,
    ST_FIN
  } state_t;

  // command from controller to datapath
  typedef struct packed {
    op_t  op;
    logic first;
    logic last;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scale_bad;
    logic mant_zero;
    logic mul_none;
    logic mul_last;
    logic sh_words_zero;
    logic overflow;
    logic steps_zero;
    logic out_full;
  } stat_t;

  // bit length of one word, zero for a zero word
  function automatic logic [5:0] word_len(input logic [WORD_W-1:0] w);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

endpackage

### design/dtb_datapath.sv
// ----------------------------------------------------------------------------
// dtb_datapath
// Rotating big-integer registers for numerator and denominator, word-serial
// multiply by five, bit length, shift, compare and subtract, plus the
// exponent, quotient and rounding logic and the output register.
// ----------------------------------------------------------------------------
module dtb_datapath #(
  parameter int BIG_WORDS   = dtb_pkg::BIG_WORDS_DEF,
  parameter int SCALE_LIMIT = dtb_pkg::SCALE_LIMIT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dtb_pkg::cmd_t                        cmd,
  output dtb_pkg::stat_t                       stat,
  input  logic [dtb_pkg::MANT_W-1:0]           mantissa,
  input  logic signed [dtb_pkg::SCALE_W-1:0]   dec_exponent,
  input  logic                                 negative,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [dtb_pkg::RES_W-1:0]            result_bits,
  output logic [dtb_pkg::STAT_W-1:0]           status
);
  import dtb_pkg::*;

  localparam int BIG_BITS = BIG_WORDS * WORD_W;
  localparam int BIT_W    = $clog2(BIG_BITS + 1);
  localparam int EW       = BIT_W + 3;

  localparam logic signed [EW-1:0]        E_MAX  = EW'(EXP_MAX);
  localparam logic signed [EW-1:0]        E_MIN  = EW'(EXP_MIN);
  localparam logic signed [EW-1:0]        E_BIAS = EW'(EXP_BIAS);
  localparam logic signed [SCALE_W:0]     SL_POS = (SCALE_W + 1)'(SCALE_LIMIT);
  localparam logic signed [SCALE_W:0]     SL_NEG = (SCALE_W + 1)'(-SCALE_LIMIT);

  // big registers, word 0 is the one being worked on
  logic [BIG_WORDS-1:0][WORD_W-1:0] num, den;

  // item registers
  logic signed [SCALE_W-1:0] s;
  logic                      sign;
  logic                      mz;
  logic [SCALE_W-1:0]        mul_left;

  // word-serial carries and flags
  logic [2:0]        carry;
  logic              borrow, sc;
  logic              c_ne, c_gt;
  logic [WORD_W-1:0] sh_cin;

  // bit length scan
  logic [BIT_W-1:0] pos, bn, bd;

  // exponent, shift and quotient
  logic signed [EW-1:0] e0, e;
  logic                 normal;
  logic                 sh_tgt;
  logic [BIT_W-6:0]     sh_words;
  logic [4:0]           sh_bits;
  logic [TOP_W-1:0]     steps;
  logic [Q_W-1:0]       q;

  // pending result
  logic [RES_W-1:0]  res_bits;
  logic [STAT_W-1:0] res_st;

  // combinational helpers
  logic                 s_neg;
  logic [WORD_W-1:0]    w_side, w_tgt, bsh_cin, bsh_word;
  logic [2:0]           mul_cin;
  logic [WORD_W+2:0]    prod;
  logic [2*WORD_W-1:0]  bsh_wide;
  logic                 ge, lt, sub_bin, sub_sin;
  logic [WORD_W:0]      sub_diff;
  logic [BIT_W-1:0]     base;
  logic                 cmp_ne_in, cmp_gt_in;
  logic signed [EW-1:0] bn_s, bd_s, s_ext, j_val, diff_bits, e_new, delta_val;
  logic signed [EW-1:0] top_s, sh_src;
  logic [EW-1:0]        sh_mag;
  logic                 normal_new, sh_tgt_new;
  logic [TOP_W-1:0]     top6;
  logic signed [SCALE_W:0] s_wide;
  logic [SCALE_W-1:0]   scale_mag;

  // rounding
  logic                 up, carry53, ovf2;
  logic [Q_W-1:0]       qr, qf;
  logic signed [EW-1:0] ef, bexp;
  logic [RES_W-1:0]     round_bits;
  logic [STAT_W-1:0]    round_st;

  // word-serial arithmetic
  assign s_neg    = s[SCALE_W-1];
  assign w_side   = s_neg ? den[0] : num[0];
  assign mul_cin  = cmd.first ? 3'd0 : carry;
  assign prod     = (WORD_W + 3)'({w_side, 2'b00}) + (WORD_W + 3)'(w_side)
                  + (WORD_W + 3)'(mul_cin);
  assign w_tgt    = sh_tgt ? den[0] : num[0];
  assign bsh_wide = (2 * WORD_W)'(w_tgt) << sh_bits;
  assign bsh_cin  = cmd.first ? WORD_W'(0) : sh_cin;
  assign bsh_word = bsh_wide[WORD_W-1:0] | bsh_cin;
  assign ge       = c_gt | ~c_ne;
  assign lt       = c_ne & ~c_gt;
  assign sub_bin  = cmd.first ? 1'b0 : borrow;
  assign sub_sin  = cmd.first ? 1'b0 : sc;
  assign sub_diff = {1'b0, num[0]} - {1'b0, (ge ? den[0] : WORD_W'(0))}
                  - (WORD_W + 1)'(sub_bin);
  assign base      = cmd.first ? BIT_W'(0) : pos;
  assign cmp_ne_in = cmd.first ? 1'b0 : c_ne;
  assign cmp_gt_in = cmd.first ? 1'b0 : c_gt;

  // exponent estimate and shift amounts
  assign bn_s       = signed'(EW'(bn));
  assign bd_s       = signed'(EW'(bd));
  assign s_ext      = EW'(s);
  assign j_val      = bd_s - bn_s;
  assign diff_bits  = bn_s - bd_s;
  assign e_new      = e0 - EW'(lt);
  assign normal_new = e_new >= E_MIN;
  assign delta_val  = normal_new ? (EW'(FRAC_BITS) + EW'(lt)) : (EW'(SUB_SCALE) + e0);
  assign top_s      = signed'(EW'(top6));

  // quotient width, clamped to the 64-bit quotient register
  always_comb begin
    priority if (diff_bits < 0) top6 = '0;
    else if (diff_bits > EW'(TOP_MAX)) top6 = TOP_W'(TOP_MAX);
    else top6 = diff_bits[TOP_W-1:0];
  end

  // shift source for alignment, division scaling and divisor placement
  always_comb begin
    priority if (cmd.op == OP_EST) sh_src = j_val;
    else if (cmd.op == OP_EXP) sh_src = delta_val;
    else sh_src = top_s;
  end
  assign sh_tgt_new = (cmd.op == OP_TOP) ? 1'b1 : (sh_src < 0);
  assign sh_mag     = sh_src[EW-1] ? -sh_src : sh_src;

  // scale range
  assign s_wide    = (SCALE_W + 1)'(s);
  assign scale_mag = dec_exponent[SCALE_W-1] ? -dec_exponent : dec_exponent;

  // round half to even and pack
  assign up      = c_gt | (~c_ne & q[0]);
  assign qr      = q + Q_W'(up);
  assign carry53 = qr == (Q_W'(1) << PREC_BITS);
  assign qf      = carry53 ? (qr >> 1) : qr;
  assign ef      = e + EW'(carry53);
  assign ovf2    = ef > E_MAX;
  assign bexp    = ef + E_BIAS;

  always_comb begin
    if (normal) begin
      if (ovf2) begin
        round_bits = '0;
        round_st   = STAT_OVF;
      end else begin
        round_bits = {sign, bexp[EXP_FIELD_W-1:0], qf[FRAC_BITS-1:0]};
        round_st   = STAT_OK;
      end
    end else begin
      if (qr == '0) begin
        round_bits = '0;
        round_st   = STAT_UNF;
      end else begin
        round_bits = {sign, (SIGN_POS - PREC_BITS)'(0), qr[PREC_BITS-1:0]};
        round_st   = STAT_OK;
      end
    end
  end

  // status to the controller
  assign stat.scale_bad     = (s_wide > SL_POS) || (s_wide < SL_NEG);
  assign stat.mant_zero     = mz;
  assign stat.mul_none      = mul_left == '0;
  assign stat.mul_last      = mul_left == SCALE_W'(1);
  assign stat.sh_words_zero = sh_words == '0;
  assign stat.overflow      = e > E_MAX;
  assign stat.steps_zero    = steps == '0;
  assign stat.out_full      = out_valid & ~out_ready;

  // output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.op == OP_EMIT) out_valid <= 1'b1;
    end
  end

  // datapath operations
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        num      <= BIG_BITS'(mantissa);
        den      <= BIG_BITS'(1);
        s        <= dec_exponent;
        sign     <= negative;
        mz       <= mantissa == '0;
        mul_left <= scale_mag;
      end
      OP_CHECK: begin
        res_bits <= stat.scale_bad ? RES_W'(0) : {sign, (RES_W - 1)'(0)};
        res_st   <= stat.scale_bad ? STAT_SCALE : STAT_OK;
      end
      OP_MUL5: begin
        if (s_neg) den <= {prod[WORD_W-1:0], den[BIG_WORDS-1:1]};
        else num <= {prod[WORD_W-1:0], num[BIG_WORDS-1:1]};
        carry <= prod[WORD_W+2:WORD_W];
        if (cmd.last) mul_left <= mul_left - SCALE_W'(1);
      end
      OP_BITS: begin
        num <= {num[0], num[BIG_WORDS-1:1]};
        den <= {den[0], den[BIG_WORDS-1:1]};
        pos <= base + BIT_W'(WORD_W);
        if (num[0] != '0) bn <= base + BIT_W'(word_len(num[0]));
        else if (cmd.first) bn <= '0;
        if (den[0] != '0) bd <= base + BIT_W'(word_len(den[0]));
        else if (cmd.first) bd <= '0;
      end
      OP_EST: begin
        e0       <= bn_s - bd_s + s_ext;
        sh_tgt   <= sh_tgt_new;
        sh_words <= sh_mag[BIT_W-1:5];
        sh_bits  <= sh_mag[4:0];
      end
      OP_WSHIFT: begin
        if (sh_tgt) den <= {den[BIG_WORDS-2:0], WORD_W'(0)};
        else num <= {num[BIG_WORDS-2:0], WORD_W'(0)};
        sh_words <= sh_words - (BIT_W - 5)'(1);
      end
      OP_BSHIFT: begin
        if (sh_tgt) den <= {bsh_word, den[BIG_WORDS-1:1]};
        else num <= {bsh_word, num[BIG_WORDS-1:1]};
        sh_cin <= bsh_wide[2*WORD_W-1:WORD_W];
      end
      OP_CMP: begin
        num <= {num[0], num[BIG_WORDS-1:1]};
        den <= {den[0], den[BIG_WORDS-1:1]};
        if (num[0] != den[0]) begin
          c_ne <= 1'b1;
          c_gt <= num[0] > den[0];
        end else begin
          c_ne <= cmp_ne_in;
          c_gt <= cmp_gt_in;
        end
      end
      OP_EXP: begin
        e        <= e_new;
        normal   <= normal_new;
        res_bits <= '0;
        res_st   <= STAT_OVF;
        sh_tgt   <= sh_tgt_new;
        sh_words <= sh_mag[BIT_W-1:5];
        sh_bits  <= sh_mag[4:0];
      end
      OP_TOP: begin
        steps    <= top6;
        q        <= '0;
        sh_tgt   <= sh_tgt_new;
        sh_words <= sh_mag[BIT_W-1:5];
        sh_bits  <= sh_mag[4:0];
      end
      OP_QBIT: begin
        q <= {q[Q_W-2:0], ge};
      end
      OP_SUBSH: begin
        // partial remainder, less the aligned divisor when not smaller, doubled
        num    <= {{sub_diff[WORD_W-2:0], sub_sin}, num[BIG_WORDS-1:1]};
        den    <= {den[0], den[BIG_WORDS-1:1]};
        borrow <= sub_diff[WORD_W];
        sc     <= sub_diff[WORD_W-1];
        if (cmd.last && (steps != '0)) steps <= steps - TOP_W'(1);
      end
      OP_ROUND: begin
        res_bits <= round_bits;
        res_st   <= round_st;
      end
      OP_EMIT: begin
        result_bits <= res_bits;
        status      <= res_st;
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |=> out_valid)
    else $error("result not presented after emit");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> result_bits == '0)
    else $error("error status with non-zero result");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_bits) && $stable(status))
    else $error("result changed while the receiver stalls");
`endif

endmodule

### design/dtb_ctrl.sv
// ----------------------------------------------------------------------------
// dtb_ctrl
// Sequencer of the converter: walks the datapath through load, scaling by
// powers of five, exponent search, alignment, long division and rounding.
// ----------------------------------------------------------------------------
module dtb_ctrl #(
  parameter int BIG_WORDS = dtb_pkg::BIG_WORDS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dtb_pkg::stat_t stat,
  output dtb_pkg::cmd_t  cmd
);
  import dtb_pkg::*;

  localparam int IDX_W = $clog2(BIG_WORDS);

  state_t           state, state_next;
  state_t           ret, ret_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             first, last, in_pass;

  assign first = idx == '0;
  assign last  = idx == IDX_W'(BIG_WORDS - 1);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      idx   <= idx_next;
    end
  end

  // word passes share one counter
  always_comb begin
    in_pass = (state == ST_MUL) || (state == ST_BITS1) || (state == ST_SHB)
           || (state == ST_CMPE) || (state == ST_BITS2) || (state == ST_DCMP)
           || (state == ST_DSUB) || (state == ST_RCMP);
    idx_next = idx;
    if (in_pass) idx_next = last ? '0 : idx + IDX_W'(1);
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ret_next   = ret;
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.first  = first;
    cmd.last   = last;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.op = OP_CHECK;
        priority if (stat.scale_bad || stat.mant_zero) state_next = ST_FIN;
        else if (stat.mul_none) state_next = ST_BITS1;
        else state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.op = OP_MUL5;
        if (last && stat.mul_last) state_next = ST_BITS1;
      end
      ST_BITS1: begin
        cmd.op = OP_BITS;
        if (last) state_next = ST_EST;
      end
      ST_EST: begin
        cmd.op     = OP_EST;
        ret_next   = ST_CMPE;
        state_next = ST_SHW;
      end
      ST_SHW: begin
        if (stat.sh_words_zero) state_next = ST_SHB;
        else cmd.op = OP_WSHIFT;
      end
      ST_SHB: begin
        cmd.op = OP_BSHIFT;
        if (last) state_next = ret;
      end
      ST_CMPE: begin
        cmd.op = OP_CMP;
        if (last) state_next = ST_EXP;
      end
      ST_EXP: begin
        cmd.op     = OP_EXP;
        state_next = ST_OVF;
      end
      ST_OVF: begin
        if (stat.overflow) begin
          state_next = ST_FIN;
        end else begin
          ret_next   = ST_BITS2;
          state_next = ST_SHW;
        end
      end
      ST_BITS2: begin
        cmd.op = OP_BITS;
        if (last) state_next = ST_TOP;
      end
      ST_TOP: begin
        cmd.op     = OP_TOP;
        ret_next   = ST_DCMP;
        state_next = ST_SHW;
      end
      ST_DCMP: begin
        cmd.op = OP_CMP;
        if (last) state_next = ST_QBIT;
      end
      ST_QBIT: begin
        cmd.op     = OP_QBIT;
        state_next = ST_DSUB;
      end
      ST_DSUB: begin
        cmd.op = OP_SUBSH;
        if (last) state_next = stat.steps_zero ? ST_RCMP : ST_DCMP;
      end
      ST_RCMP: begin
        cmd.op = OP_CMP;
        if (last) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.op     = OP_ROUND;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.out_full) begin
          cmd.op     = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_CHECK)
    else $error("accepted transfer not followed by range check");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |-> !stat.out_full)
    else $error("emit into an occupied output register");
  a_pass_aligned: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE && $past(state) == ST_IDLE |-> idx == '0)
    else $error("word counter not at zero on a new item");
`endif

endmodule

### design/decimal_to_binary64_converter.sv
// ----------------------------------------------------------------------------
// decimal_to_binary64_converter
// Correctly rounded conversion of a decimal significand and power-of-ten
// scale to a binary64 bit pattern, with a status code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries mantissa, dec_exponent and
//   negative; output channel out_valid/out_ready carries result_bits and
//   status. Each input transfer yields exactly one output transfer.
//   One item is worked on at a time; in_ready is high whenever the
//   sequencer is idle, even while a finished result waits in the output
//   register, so the next item overlaps the stalled one.
//   The work is done in word-serial passes over BIG_WORDS words (one word
//   per cycle): one pass per power of five, then seven passes for bit
//   lengths, alignment and compares, three of them aligning after word
//   shifts of 32 bits each, and a compare and a subtract pass per bit of
//   long division. Range errors and zero mantissas go from the range
//   check straight to the emit step.
//   A result that is not taken holds the sequencer before its emit step.
//   Reset (synchronous) returns the sequencer to idle and empties the
//   output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module decimal_to_binary64_converter #(
  parameter int BIG_WORDS   = dtb_pkg::BIG_WORDS_DEF,
  parameter int SCALE_LIMIT = dtb_pkg::SCALE_LIMIT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dtb_pkg::MANT_W-1:0]         mantissa,
  input  logic signed [dtb_pkg::SCALE_W-1:0] dec_exponent,
  input  logic                               negative,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dtb_pkg::RES_W-1:0]          result_bits,
  output logic [dtb_pkg::STAT_W-1:0]         status
);
  import dtb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  dtb_ctrl #(
    .BIG_WORDS (BIG_WORDS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // big-integer datapath and output register
  dtb_datapath #(
    .BIG_WORDS   (BIG_WORDS),
    .SCALE_LIMIT (SCALE_LIMIT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mantissa      (mantissa),
    .dec_exponent  (dec_exponent),
    .negative      (negative),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .result_bits   (result_bits),
    .status        (status)
  );

endmodule

### tb/decimal_to_binary64_converter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_to_binary64_converter_checker
// Watches both channels of the converter. Every input transfer is turned into
// an expected binary64 pattern and status by an exact big-integer predictor.
// Every output transfer is compared field by field with the oldest
// expectation. Mismatches and unexpected results are counted as failures.
// ----------------------------------------------------------------------------
module decimal_to_binary64_converter_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [dtb_pkg::MANT_W-1:0]         mantissa,
  input  logic signed [dtb_pkg::SCALE_W-1:0] dec_exponent,
  input  logic                               negative,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [dtb_pkg::RES_W-1:0]          result_bits,
  input  logic [dtb_pkg::STAT_W-1:0]         status,
  output int                                 fail_count,
  output int                                 pending_count,
  output int                                 result_count
);
  import dtb_pkg::*;

  localparam int BW        = BIG_WORDS_DEF * WORD_W;
  localparam int SCALE_MAX = SCALE_LIMIT_DEF;

  typedef logic [BW-1:0] big_t;

  typedef struct packed {
    logic [RES_W-1:0]  bits;
    logic [STAT_W-1:0] st;
  } conv_result_t;

  conv_result_t expected_results[$];
  int           mismatch_count;

  // number of significant bits of a big value
  function automatic int big_len(input big_t v);
    int n;
    n = 0;
    for (int i = BW - 1; i >= 0; i--) begin
      if (v[i]) begin
        n = i + 1;
        break;
      end
    end
    return n;
  endfunction

  // multiply one side of the ratio by 2^k
  function automatic void shift_ratio(input big_t n, input big_t d, input int k,
                                      output big_t n_out, output big_t d_out);
    if (k >= 0) begin
      n_out = n << k;
      d_out = d;
    end else begin
      n_out = n;
      d_out = d << (-k);
    end
  endfunction

  // exactly rounded binary64 pattern and status of one input
  function automatic conv_result_t predict_binary64(input logic [MANT_W-1:0] m,
                                                    input logic signed [SCALE_W-1:0] sc,
                                                    input logic neg);
    big_t         num, den, a, b, rem, dv, trial, twice;
    int           s, e, k, top, cnt;
    logic [63:0]  q, sign;
    bit           normal;
    conv_result_t r;
    s      = int'(sc);
    sign   = neg ? (64'd1 << SIGN_POS) : 64'd0;
    r.bits = '0;
    r.st   = STAT_OK;
    if (s > SCALE_MAX || s < -SCALE_MAX) begin
      r.st = STAT_SCALE;
      return r;
    end
    if (m == 0) begin
      r.bits = sign;
      return r;
    end
    num = BW'(m);
    den = BW'(1);
    cnt = (s < 0) ? -s : s;
    for (int i = 0; i < cnt; i++) begin
      if (s < 0) den = den * 5;
      else num = num * 5;
    end
    // exponent estimate, corrected by one exact comparison
    e = big_len(num) - big_len(den) + s;
    shift_ratio(num, den, s - e, a, b);
    if (a < b) e--;
    if (e > EXP_MAX) begin
      r.st = STAT_OVF;
      return r;
    end
    normal = (e >= EXP_MIN);
    k = normal ? (s + FRAC_BITS - e) : (s + SUB_SCALE);
    // long division with half-even rounding
    shift_ratio(num, den, k, rem, dv);
    top = big_len(rem) - big_len(dv);
    if (top > TOP_MAX) top = TOP_MAX;
    q = '0;
    for (int i = top; i >= 0; i--) begin
      trial = dv << i;
      if (rem >= trial) begin
        rem  = rem - trial;
        q[i] = 1'b1;
      end
    end
    twice = rem << 1;
    if (twice > dv || (twice == dv && q[0])) q = q + 1;
    if (normal) begin
      if (q == (64'd1 << PREC_BITS)) begin
        q = q >> 1;
        e++;
      end
      if (e > EXP_MAX) begin
        r.st = STAT_OVF;
        return r;
      end
      r.bits = sign | (64'(e + EXP_BIAS) << FRAC_BITS) | (q & ((64'd1 << FRAC_BITS) - 1));
    end else begin
      if (q == 0) begin
        r.st = STAT_UNF;
        return r;
      end
      r.bits = sign | (q & ((64'd1 << PREC_BITS) - 1));
    end
    return r;
  endfunction

  assign pending_count = expected_results.size();

  // compare output transfers first, then queue the prediction for an input
  always @(posedge clk) begin
    conv_result_t exp_r;
    if (rst) begin
      fail_count     <= 0;
      result_count   <= 0;
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          fail_count <= fail_count + 1;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: bits %h status %0d", result_bits, status);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.bits !== result_bits || exp_r.st !== status) begin
            fail_count <= fail_count + 1;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected bits %h status %0d, got bits %h status %0d",
                       exp_r.bits, exp_r.st, result_bits, status);
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_binary64(mantissa, dec_exponent, negative));
    end
  end

endmodule

### tb/decimal_to_binary64_converter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_to_binary64_converter_tb
// Drives the converter with directed corner values and random decimal
// numbers, with bursty input traffic, a stalling receiver and one long
// output hold-off. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module decimal_to_binary64_converter_tb;
  import dtb_pkg::*;

  localparam int LIMIT_CYCLES = 15_000_000;
  localparam int HOLD_CYCLES  = 40_000;
  localparam int RANDOM_ITEMS = 80;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [MANT_W-1:0]         mantissa = '0;
  logic signed [SCALE_W-1:0] dec_exponent = '0;
  logic                      negative = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [RES_W-1:0]          result_bits;
  logic [STAT_W-1:0]         status;
  int                        fail_count;
  int                        pending_count;
  int                        result_count;
  int                        sent_count = 0;
  int                        cycle_count = 0;

  always #5 clk = ~clk;

  decimal_to_binary64_converter i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mantissa(mantissa), .dec_exponent(dec_exponent), .negative(negative),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_bits(result_bits), .status(status)
  );

  decimal_to_binary64_converter_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mantissa(mantissa), .dec_exponent(dec_exponent), .negative(negative),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_bits(result_bits), .status(status),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("decimal_to_binary64_converter_tb failed");
      $finish;
    end
  end

  // receiver: changing stall pattern, one long hold-off after a few results
  initial begin
    int mode;
    bit held;
    held = 1'b0;
    mode = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && result_count >= 12) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 99) == 0) mode = $urandom_range(0, 2);
      unique case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
      @(posedge clk);
    end
  end

  // one input transfer, then maybe a gap ending the burst
  task automatic send_number(input logic [MANT_W-1:0] m, input int s, input logic neg);
    int gap;
    in_valid     <= 1'b1;
    mantissa     <= m;
    dec_exponent <= SCALE_W'(s);
    negative     <= neg;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // random decimal number, mostly small scales
  task automatic send_random_number();
    logic [MANT_W-1:0] m;
    int s, pick;
    m = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 1) m = m >> $urandom_range(0, 63);
    if ($urandom_range(0, 19) == 0) m = '0;
    pick = $urandom_range(0, 99);
    if (pick < 60) s = $urandom_range(0, 50) - 25;
    else if (pick < 72) s = -$urandom_range(300, 345);
    else if (pick < 80) s = $urandom_range(280, 320);
    else if (pick < 90) s = $urandom_range(0, 800) - 400;
    else begin
      // out of range, any ten-bit pattern beyond the limit
      s = $urandom_range(401, 511);
      if ($urandom_range(0, 1) == 1) s = -$urandom_range(401, 512);
    end
    send_number(m, s, 1'($urandom_range(0, 1)));
  endtask

  // stimulus and verdict
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed corners
    send_number(64'd0, 0, 1'b0);
    send_number(64'd0, -7, 1'b1);
    send_number(64'd0, 401, 1'b0);
    send_number(64'd5, -401, 1'b1);
    send_number(64'd1, -512, 1'b0);
    send_number('1, 511, 1'b1);
    send_number(64'd1, 0, 1'b0);
    send_number('1, 0, 1'b1);
    send_number(64'd123456789, -5, 1'b1);
    send_number(64'd1, 400, 1'b0);
    send_number(64'd1, -400, 1'b1);
    send_number('1, 400, 1'b0);
    send_number('1, -400, 1'b0);
    send_number(64'd5, -324, 1'b0);
    send_number(64'd2, -324, 1'b0);
    send_number(64'd3, -324, 1'b1);
    send_number(64'd1, -323, 1'b0);
    send_number(64'd17976931348623157, 292, 1'b0);
    send_number(64'd17976931348623159, 292, 1'b1);
    send_number(64'd22250738585072011, -324, 1'b0);
    send_number(64'd22250738585072014, -324, 1'b1);
    send_number(64'd9007199254740993, 0, 1'b0);
    send_number(64'd9007199254740995, 0, 1'b0);
    // random part
    repeat (RANDOM_ITEMS) send_random_number();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d numbers, checked %0d results, %0d failures",
             sent_count, result_count, fail_count);
    $display("covered zeros, range errors, overflow, underflow, subnormals and ties");
    if (fail_count == 0 && pending_count == 0) begin
      $display("decimal_to_binary64_converter_tb passed");
    end else begin
      $display("decimal_to_binary64_converter_tb failed");
    end
    $finish;
  end

endmodule
